// ----- rtl/apbf_pkg.sv -----
`timescale 1ns / 1ps
// apbf_pkg: constants, types and codes shared by the age-partitioned bloom filter
// no dependencies
package apbf_pkg;

  localparam int MAX_HASH_N       = 16;
  localparam int MAX_BATCHES_N    = 16;
  localparam int MAX_SLICE_BITS_N = 4096;

  localparam int NSLOTS    = MAX_HASH_N + MAX_BATCHES_N;
  localparam int WORDS     = (MAX_SLICE_BITS_N + 63) / 64;
  localparam int SLOT_W    = $clog2(NSLOTS);
  localparam int WORD_W    = $clog2(WORDS);
  localparam int ADDR_W    = SLOT_W + WORD_W;
  localparam int MEM_DEPTH = NSLOTS * WORDS;
  localparam int POS_W     = WORD_W + 6;
  localparam int HIDX_W    = $clog2(MAX_HASH_N);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MOD_DIGITS = 4;
  localparam int MOD_STEPS  = 64 / MOD_DIGITS;

  localparam int WALK_LIMIT = 4 * NSLOTS * MAX_HASH_N + 16;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);

  localparam logic [4:0]  MAX_HASH       = 5'(MAX_HASH_N);
  localparam logic [4:0]  MAX_BATCHES    = 5'(MAX_BATCHES_N);
  localparam logic [12:0] MAX_SLICE_BITS = 13'(MAX_SLICE_BITS_N);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_HASH    = 2'd0,
    REG_NUM_BATCHES = 2'd1,
    REG_SLICE_BITS  = 2'd2,
    REG_GEN_SIZE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RET   = 11'b00000000100,
    S_SLOT  = 11'b00000001000,
    S_HASH  = 11'b00000010000,
    S_WAIT  = 11'b00000100000,
    S_RD    = 11'b00001000000,
    S_WR    = 11'b00010000000,
    S_QTEST = 11'b00100000000,
    S_QCHK  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ----- rtl/apbf_if.sv -----
`timescale 1ns / 1ps
// apbf_item_if / apbf_result_if: valid-ready channels of the filter
// no dependencies
interface apbf_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] hash_a;
  logic [63:0] hash_b;
  modport source (output valid, op, hash_a, hash_b, input ready);
  modport sink (input valid, op, hash_a, hash_b, output ready);
endinterface

interface apbf_result_if;
  logic valid;
  logic ready;
  logic found;
  logic shifted;
  modport source (output valid, found, shifted, input ready);
  modport sink (input valid, found, shifted, output ready);
endinterface

// ----- rtl/apbf_mod_unit.sv -----
`timescale 1ns / 1ps
// apbf_mod_unit: iterative remainder of a 64-bit value by the slice size
// depends on apbf_pkg
module apbf_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  apbf_pkg::mod_req_t req,
  input  logic [12:0]       modulus,
  output apbf_pkg::mod_rsp_t rsp
);
  import apbf_pkg::*;

  logic                         busy;
  logic [$clog2(MOD_STEPS)-1:0] cnt;
  logic [63:0]                  x;
  logic [POS_W-1:0]             r;
  logic                         done;
  logic [12:0]                  rr;
  logic [12:0]                  t;

  // restoring remainder, a few dividend bits per cycle
  always_comb begin
    rr = {1'b0, r};
    t  = '0;
    for (int d = 0; d < MOD_DIGITS; d++) begin
      t  = {rr[POS_W-1:0], x[63-d]};
      rr = (t >= modulus) ? t - modulus : t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= req.dividend;
        r    <= '0;
      end else if (busy) begin
        x   <= x << MOD_DIGITS;
        r   <= rr[POS_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(MOD_STEPS))'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("remainder done without a running division");

endmodule

// ----- rtl/apbf_slice_mem.sv -----
`timescale 1ns / 1ps
// apbf_slice_mem: slice bit store, one write and one registered read per cycle
// depends on apbf_pkg
module apbf_slice_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [apbf_pkg::ADDR_W-1:0] waddr,
  input  logic [63:0]                 wdata,
  input  logic [apbf_pkg::ADDR_W-1:0] raddr,
  output logic [63:0]                 rdata
);
  import apbf_pkg::*;

  logic [63:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/age_partitioned_bloom_filter_core.sv -----
`timescale 1ns / 1ps
// age_partitioned_bloom_filter_core: sequencer around one remainder unit and the slice store
// depends on apbf_pkg, apbf_if, apbf_mod_unit, apbf_slice_mem
// each slice visit on insert steps through S_SLOT, S_HASH, S_WAIT, S_RD and S_WR, waiting on the remainder unit
// insert: one slice visit per hash, plus clearing of the slot when the oldest slice is retired
// query: one slice visit per cursor step, one request at a time
// reset and any write of num_hash, num_batches or slice_bits start a clearing pass
// over every word of the slice store; no request is taken until it ends
module age_partitioned_bloom_filter_core (
  input  logic                            clk,
  input  logic                            rst,
  apbf_item_if.sink                       item,
  apbf_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [apbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import apbf_pkg::*;

  state_t state;

  logic [4:0]  num_hash;
  logic [4:0]  num_batches;
  logic [12:0] slice_bits;
  logic [31:0] gen_size;

  logic [4:0]  k_eff;
  logic [4:0]  l_eff;
  logic [5:0]  n_eff;
  logic [12:0] m_eff;

  logic [HIDX_W-1:0] shi [NSLOTS];
  logic [SLOT_W-1:0] newest;
  logic [31:0]       phase;

  logic        op_q;
  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [SLOT_W-1:0] slot;
  logic [POS_W-1:0]  pos;
  logic [4:0]        ins_i;
  logic signed [6:0] cursor;
  logic [4:0]        qdone;
  logic [4:0]        carry;
  logic [STEP_W-1:0] steps;
  logic [ADDR_W-1:0] clr_cnt;
  logic [WORD_W-1:0] wcnt;
  logic [HIDX_W-1:0] hmod;
  logic              found_q;
  logic              shifted_q;

  logic res_valid;
  logic res_found;
  logic res_shifted;

  logic [5:0]        logical;
  logic [6:0]        psum;
  logic [6:0]        phys;
  logic [6:0]        osum;
  logic [6:0]        old_slot;
  logic [HIDX_W-1:0] prev_idx;
  logic [HIDX_W-1:0] new_idx;
  logic              retire;
  logic              accept;
  logic              hit;
  logic [5:0]        run;
  logic              geo_wr;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [63:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [63:0]       mem_rdata;

  always_comb begin
    k_eff = (num_hash == 5'd0) ? 5'd1 : ((num_hash > MAX_HASH) ? MAX_HASH : num_hash);
    l_eff = (num_batches == 5'd0) ? 5'd1 :
            ((num_batches > MAX_BATCHES) ? MAX_BATCHES : num_batches);
    n_eff = {1'b0, k_eff} + {1'b0, l_eff};
    m_eff = (slice_bits == 13'd0) ? 13'd1 :
            ((slice_bits > MAX_SLICE_BITS) ? MAX_SLICE_BITS : slice_bits);
    geo_wr = cfg_we && (cfg_index != REG_GEN_SIZE);
  end

  // logical slice to physical slot, ring of n slots
  always_comb begin
    logical  = op_q ? cursor[5:0] : {1'b0, ins_i};
    psum     = {2'b00, newest} + {1'b0, logical};
    phys     = (psum >= {1'b0, n_eff}) ? psum - {1'b0, n_eff} : psum;
    osum     = {2'b00, newest} + {1'b0, n_eff} - 7'd1;
    old_slot = (osum >= {1'b0, n_eff}) ? osum - {1'b0, n_eff} : osum;
    prev_idx = shi[newest];
    new_idx  = (prev_idx == '0) ? HIDX_W'(k_eff - 5'd1) : prev_idx - 1'b1;
    retire   = ({1'b0, phase} + 33'd1) >= {1'b0, gen_size};
    accept   = item.valid && item.ready;
    hit      = mem_rdata[pos[5:0]];
    run      = {1'b0, qdone} + 6'd1 + {1'b0, carry};
  end

  assign item.ready     = (state == S_IDLE);
  assign result.valid   = res_valid;
  assign result.found   = res_found;
  assign result.shifted = res_shifted;

  assign mod_req.start    = (state == S_HASH);
  assign mod_req.dividend = a_q + (b_q * 64'(shi[slot]));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {slot, pos[POS_W-1:6]};
    mem_wdata = mem_rdata | (64'd1 << pos[5:0]);
    mem_raddr = {slot, pos[POS_W-1:6]};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_RET: begin
        mem_we    = 1'b1;
        mem_waddr = {newest, wcnt};
        mem_wdata = '0;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // hash index per slot; filled by the clearing pass, rewritten on retire
  always_ff @(posedge clk) begin
    if (state == S_CLEAR && clr_cnt[WORD_W-1:0] == '0) begin
      shi[clr_cnt[ADDR_W-1:WORD_W]] <= hmod;
    end else if (accept && !item.op && retire) begin
      shi[old_slot[SLOT_W-1:0]] <= new_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      num_hash    <= 5'd4;
      num_batches <= 5'd3;
      slice_bits  <= 13'd4096;
      gen_size    <= 32'd709;
      newest      <= '0;
      phase       <= '0;
      clr_cnt     <= '0;
      hmod        <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && result.ready && (geo_wr || state != S_DONE)) begin
        res_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_HASH: begin
            num_hash <= cfg_data[4:0];
          end
          REG_NUM_BATCHES: begin
            num_batches <= cfg_data[4:0];
          end
          REG_SLICE_BITS: begin
            slice_bits <= cfg_data[12:0];
          end
          REG_GEN_SIZE: begin
            gen_size <= cfg_data;
          end
          default: begin
            gen_size <= gen_size;
          end
        endcase
      end

      // geometry writes rebuild the whole filter
      if (geo_wr) begin
        state   <= S_CLEAR;
        clr_cnt <= '0;
        hmod    <= '0;
        newest  <= '0;
        phase   <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            if (clr_cnt[WORD_W-1:0] == '0) begin
              hmod <= (5'(hmod) + 5'd1 >= k_eff) ? '0 : hmod + 1'b1;
            end
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == ADDR_W'(MEM_DEPTH - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              op_q      <= item.op;
              a_q       <= item.hash_a;
              b_q       <= item.hash_b;
              found_q   <= 1'b0;
              shifted_q <= 1'b0;
              ins_i     <= '0;
              cursor    <= $signed({2'b00, l_eff});
              qdone     <= '0;
              carry     <= '0;
              steps     <= '0;
              wcnt      <= '0;
              if (item.op) begin
                state <= S_QTEST;
              end else if (retire) begin
                newest    <= old_slot[SLOT_W-1:0];
                phase     <= '0;
                shifted_q <= 1'b1;
                state     <= S_RET;
              end else begin
                phase <= phase + 32'd1;
                state <= S_SLOT;
              end
            end
          end
          S_RET: begin
            wcnt <= wcnt + 1'b1;
            if (wcnt == '1) begin
              state <= S_SLOT;
            end
          end
          S_SLOT: begin
            slot  <= phys[SLOT_W-1:0];
            state <= S_HASH;
          end
          S_HASH: begin
            state <= S_WAIT;
          end
          S_WAIT: begin
            if (mod_rsp.done) begin
              pos   <= mod_rsp.rem;
              state <= S_RD;
            end
          end
          S_RD: begin
            state <= op_q ? S_QCHK : S_WR;
          end
          S_WR: begin
            if (ins_i + 5'd1 == k_eff) begin
              state <= S_DONE;
            end else begin
              ins_i <= ins_i + 5'd1;
              state <= S_SLOT;
            end
          end
          S_QTEST: begin
            if (!cursor[6] && cursor < $signed({1'b0, n_eff}) &&
                steps < STEP_W'(WALK_LIMIT)) begin
              state <= S_SLOT;
            end else begin
              state <= S_DONE;
            end
          end
          S_QCHK: begin
            steps <= steps + 1'b1;
            if (hit) begin
              if (run == {1'b0, k_eff}) begin
                found_q <= 1'b1;
                state   <= S_DONE;
              end else begin
                qdone  <= qdone + 5'd1;
                cursor <= cursor + 7'sd1;
                state  <= S_QTEST;
              end
            end else begin
              cursor <= cursor - $signed({2'b00, k_eff});
              carry  <= qdone;
              qdone  <= '0;
              state  <= S_QTEST;
            end
          end
          S_DONE: begin
            if (!res_valid || result.ready) begin
              res_valid   <= 1'b1;
              res_found   <= found_q;
              res_shifted <= shifted_q;
              state       <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  apbf_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .req     (mod_req),
    .modulus (m_eff),
    .rsp     (mod_rsp)
  );

  apbf_slice_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_hash_then_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_HASH && !cfg_we) |=> state == S_WAIT) else $error("hash start not followed by wait");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == S_WAIT) else $error("remainder result outside wait");

  a_slot_in_ring: assert property (@(posedge clk) disable iff (rst)
    state == S_HASH |-> {1'b0, slot} < n_eff) else $error("slot outside the ring");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_DONE)) else $error("result without finished request");

endmodule
